/* hw/rtl/dte_pkg.sv */
// dte_pkg: shared types, codes and constants for the datetime text to epoch block
// used by dte_parser, dte_mac, dte_conv and datetime_text_to_epoch_ms_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dte_pkg;

    localparam int MAX_FORMAT_LEN_DEF = 32;

    localparam int TS_W    = 53;
    localparam int MAC_A_W = 25;
    localparam int MAC_B_W = 28;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_FMT0 = 3'd0;
    localparam logic [2:0] REG_FMT1 = 3'd1;
    localparam logic [2:0] REG_FMT2 = 3'd2;
    localparam logic [2:0] REG_FMT3 = 3'd3;
    localparam logic [2:0] REG_LEN  = 3'd4;

    // format letters
    localparam logic [7:0] CH_YEAR   = 8'h59; // Y
    localparam logic [7:0] CH_MONTH  = 8'h4D; // M
    localparam logic [7:0] CH_DAY    = 8'h44; // D
    localparam logic [7:0] CH_HOUR   = 8'h68; // h
    localparam logic [7:0] CH_MINUTE = 8'h6D; // m
    localparam logic [7:0] CH_SECOND = 8'h73; // s
    localparam logic [7:0] CH_MILLI  = 8'h66; // f
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [13:0] YEAR_MAX    = 14'd16383;
    localparam logic [9:0]  FIELD10_MAX = 10'd1023;

    // multiplier constants of the calendar conversion
    localparam logic signed [MAC_B_W-1:0] K_DIV400   = 28'sd41944;    // 2^24/400 rounded up
    localparam logic signed [MAC_B_W-1:0] K_NEG400   = -28'sd400;
    localparam logic signed [MAC_B_W-1:0] K_DIV100   = 28'sd41;       // 2^12/100 rounded up
    localparam logic signed [MAC_B_W-1:0] K_153      = 28'sd153;
    localparam logic signed [MAC_B_W-1:0] K_DIV5     = 28'sd209716;   // 2^20/5 rounded up
    localparam logic signed [MAC_B_W-1:0] K_365      = 28'sd365;
    localparam logic signed [MAC_B_W-1:0] K_ERA_DAYS = 28'sd146097;
    localparam logic signed [MAC_B_W-1:0] K_DAY_MS   = 28'sd86400000;
    localparam logic signed [MAC_B_W-1:0] K_HOUR_MS  = 28'sd3600000;
    localparam logic signed [MAC_B_W-1:0] K_MIN_MS   = 28'sd60000;
    localparam logic signed [MAC_B_W-1:0] K_SEC_MS   = 28'sd1000;
    localparam logic signed [TS_W-1:0]    K_EPOCH_DAYS = 53'sd719468;

    typedef struct packed {
        logic [13:0] year;
        logic [9:0]  month;
        logic [9:0]  day;
        logic [9:0]  hour;
        logic [9:0]  minute;
        logic [9:0]  second;
        logic [9:0]  milli;
    } t_fields;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } t_req;

endpackage

`default_nettype wire

/* hw/rtl/dte_parser.sv */
// dte_parser: matches text bytes against the format and accumulates the date fields
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_parser #(
    parameter int MAX_FORMAT_LEN = dte_pkg::MAX_FORMAT_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_start,
    input  wire logic [255:0]      i_fmt,
    input  wire logic [5:0]        i_len,
    output dte_pkg::t_fields       o_fields,
    output dte_pkg::t_req          o_req
);

    localparam logic [6:0] MAX_LEN = 7'(MAX_FORMAT_LEN);

    logic [5:0]       r_position, n_position;
    logic             r_active, n_active;
    logic             r_ovf, n_ovf;
    dte_pkg::t_fields r_fields, n_fields;

    dte_pkg::t_fields base;
    dte_pkg::t_req    req;
    logic             act;
    logic [5:0]       pos;
    logic [5:0]       next_pos;
    logic             base_ovf;
    logic [7:0]       fmt_ch;
    logic             is_digit;
    logic [3:0]       digit;
    logic             is_letter;
    logic [9:0]       cur10;
    logic [13:0]      acc10;
    logic [9:0]       sat10;
    logic             ovf10;
    logic [17:0]      acc_year;
    logic [13:0]      sat_year;
    logic             ovf_year;
    logic [6:0]       len_clip;
    logic [6:0]       len_eff;
    logic             done;
    logic             fail;

    assign act      = i_start | r_active;
    assign pos      = i_start ? 6'd0 : r_position;
    assign base     = i_start ? '0 : r_fields;
    assign base_ovf = i_start ? 1'b0 : r_ovf;
    assign next_pos = pos + 6'd1;

    // positions past the four format words read as zero
    assign fmt_ch = pos[5] ? 8'd0 : i_fmt[{pos[4:0], 3'b000} +: 8];

    assign is_digit = (i_char >= dte_pkg::CH_ZERO) && (i_char <= dte_pkg::CH_NINE);
    assign digit    = is_digit ? 4'(i_char - dte_pkg::CH_ZERO) : 4'd0;

    always_comb begin
        is_letter = 1'b1;
        cur10     = base.month;
        unique case (fmt_ch)
            dte_pkg::CH_YEAR:   cur10 = base.month;
            dte_pkg::CH_MONTH:  cur10 = base.month;
            dte_pkg::CH_DAY:    cur10 = base.day;
            dte_pkg::CH_HOUR:   cur10 = base.hour;
            dte_pkg::CH_MINUTE: cur10 = base.minute;
            dte_pkg::CH_SECOND: cur10 = base.second;
            dte_pkg::CH_MILLI:  cur10 = base.milli;
            default:            is_letter = 1'b0;
        endcase
    end

    // field * 10 + digit, saturating at the field's all-ones value
    assign acc10    = ({4'd0, cur10} << 3) + ({4'd0, cur10} << 1) + {10'd0, digit};
    assign ovf10    = acc10 > {4'd0, dte_pkg::FIELD10_MAX};
    assign sat10    = ovf10 ? dte_pkg::FIELD10_MAX : acc10[9:0];
    assign acc_year = ({4'd0, base.year} << 3) + ({4'd0, base.year} << 1) + {14'd0, digit};
    assign ovf_year = acc_year > {4'd0, dte_pkg::YEAR_MAX};
    assign sat_year = ovf_year ? dte_pkg::YEAR_MAX : acc_year[13:0];

    assign len_clip = (i_len == 6'd0) ? 7'd1 : {1'b0, i_len};
    assign len_eff  = (len_clip > MAX_LEN) ? MAX_LEN : len_clip;
    assign done     = {1'b0, next_pos} >= len_eff;
    assign fail     = is_letter ? !is_digit : (i_char != fmt_ch);

    always_comb begin
        n_position = r_position;
        n_active   = r_active;
        n_ovf      = r_ovf;
        n_fields   = r_fields;
        req        = '0;
        if (i_accept && act) begin
            n_fields   = base;
            n_ovf      = base_ovf;
            n_position = pos;
            if (fail) begin
                n_active   = 1'b0;
                req.valid  = 1'b1;
                req.status = dte_pkg::ST_MISMATCH;
            end else begin
                if (is_letter) begin
                    if (fmt_ch == dte_pkg::CH_YEAR) begin
                        n_fields.year = sat_year;
                        n_ovf         = base_ovf | ovf_year;
                    end else begin
                        n_ovf = base_ovf | ovf10;
                        unique case (fmt_ch)
                            dte_pkg::CH_MONTH:  n_fields.month  = sat10;
                            dte_pkg::CH_DAY:    n_fields.day    = sat10;
                            dte_pkg::CH_HOUR:   n_fields.hour   = sat10;
                            dte_pkg::CH_MINUTE: n_fields.minute = sat10;
                            dte_pkg::CH_SECOND: n_fields.second = sat10;
                            default:            n_fields.milli  = sat10;
                        endcase
                    end
                end
                n_position = next_pos;
                if (done) begin
                    n_active   = 1'b0;
                    req.valid  = 1'b1;
                    req.status = n_ovf ? dte_pkg::ST_OVERFLOW : dte_pkg::ST_OK;
                end else begin
                    n_active = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_active   <= 1'b0;
            r_ovf      <= 1'b0;
            r_fields   <= '0;
        end else begin
            r_position <= n_position;
            r_active   <= n_active;
            r_ovf      <= n_ovf;
            r_fields   <= n_fields;
        end
    end

    assign o_fields = r_fields;
    assign o_req    = req;

endmodule

`default_nettype wire

/* hw/rtl/dte_mac.sv */
// dte_mac: shared signed multiply-add unit, p = a * b + c
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_mac (
    input  wire logic signed [dte_pkg::MAC_A_W-1:0] i_a,
    input  wire logic signed [dte_pkg::MAC_B_W-1:0] i_b,
    input  wire logic signed [dte_pkg::TS_W-1:0]    i_c,
    output logic signed [dte_pkg::TS_W-1:0]         o_p
);

    assign o_p = i_a * i_b + i_c;

endmodule

`default_nettype wire

/* hw/rtl/dte_conv.sv */
// dte_conv: sequencer that turns the parsed fields into epoch milliseconds
// runs every step through one dte_mac; depends on dte_pkg and dte_mac
`timescale 1ns / 1ps
`default_nettype none

module dte_conv (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire dte_pkg::t_req             i_req,
    input  wire dte_pkg::t_fields          i_fields,
    input  wire logic                      i_out_free,
    output logic                           o_idle,
    output logic                           o_res_valid,
    output logic [dte_pkg::TS_W-1:0]       o_res_ts,
    output logic [1:0]                     o_res_status
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_ERA  = 13'b0000000000010,
        S_YOE  = 13'b0000000000100,
        S_Q100 = 13'b0000000001000,
        S_MP   = 13'b0000000010000,
        S_DOY  = 13'b0000000100000,
        S_DOE  = 13'b0000001000000,
        S_DAYS = 13'b0000010000000,
        S_MSD  = 13'b0000100000000,
        S_MSH  = 13'b0001000000000,
        S_MSM  = 13'b0010000000000,
        S_MSS  = 13'b0100000000000,
        S_HOLD = 13'b1000000000000
    } t_state;

    t_state                           r_state;
    logic [5:0]                       r_era1;
    logic [8:0]                       r_yoe;
    logic [1:0]                       r_q100;
    logic [17:0]                      r_t;
    logic [14:0]                      r_doy0;
    logic signed [18:0]               r_doe;
    logic signed [dte_pkg::TS_W-1:0]  r_acc;
    logic [1:0]                       r_status;

    logic signed [dte_pkg::MAC_A_W-1:0] mac_a;
    logic signed [dte_pkg::MAC_B_W-1:0] mac_b;
    logic signed [dte_pkg::TS_W-1:0]    mac_c;
    logic signed [dte_pkg::TS_W-1:0]    mac_p;

    logic [14:0]        yp;
    logic [9:0]         mp;
    logic signed [19:0] doe_c;
    logic signed [6:0]  era;

    // year shifted by one for january and february, plus one era to keep it positive
    assign yp = {1'b0, i_fields.year} + 15'd400
              - {14'd0, (i_fields.month <= 10'd2)};
    assign mp = (i_fields.month > 10'd2) ? i_fields.month - 10'd3 : i_fields.month + 10'd9;
    assign doe_c = $signed({13'd0, r_yoe[8:2]}) - $signed({18'd0, r_q100})
                 + $signed({5'd0, r_doy0}) + $signed({10'd0, i_fields.day}) - 20'sd1;
    assign era = $signed({1'b0, r_era1}) - 7'sd1;

    always_comb begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
        unique case (r_state)
            S_ERA: begin
                mac_a = {10'd0, yp};
                mac_b = dte_pkg::K_DIV400;
            end
            S_YOE: begin
                mac_a = {19'd0, r_era1};
                mac_b = dte_pkg::K_NEG400;
                mac_c = {38'd0, yp};
            end
            S_Q100: begin
                mac_a = {16'd0, r_yoe};
                mac_b = dte_pkg::K_DIV100;
            end
            S_MP: begin
                mac_a = {15'd0, mp};
                mac_b = dte_pkg::K_153;
                mac_c = 53'sd2;
            end
            S_DOY: begin
                mac_a = {7'd0, r_t};
                mac_b = dte_pkg::K_DIV5;
            end
            S_DOE: begin
                mac_a = {16'd0, r_yoe};
                mac_b = dte_pkg::K_365;
                mac_c = 53'(doe_c);
            end
            S_DAYS: begin
                mac_a = 25'(era);
                mac_b = dte_pkg::K_ERA_DAYS;
                mac_c = 53'(r_doe) - dte_pkg::K_EPOCH_DAYS;
            end
            S_MSD: begin
                mac_a = r_acc[dte_pkg::MAC_A_W-1:0];
                mac_b = dte_pkg::K_DAY_MS;
                mac_c = {43'd0, i_fields.milli};
            end
            S_MSH: begin
                mac_a = {15'd0, i_fields.hour};
                mac_b = dte_pkg::K_HOUR_MS;
                mac_c = r_acc;
            end
            S_MSM: begin
                mac_a = {15'd0, i_fields.minute};
                mac_b = dte_pkg::K_MIN_MS;
                mac_c = r_acc;
            end
            S_MSS: begin
                mac_a = {15'd0, i_fields.second};
                mac_b = dte_pkg::K_SEC_MS;
                mac_c = r_acc;
            end
            default: begin
                mac_a = '0;
            end
        endcase
    end

    dte_mac u_mac (
        .i_a (mac_a),
        .i_b (mac_b),
        .i_c (mac_c),
        .o_p (mac_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.status == dte_pkg::ST_OK) begin
                            r_state <= S_ERA;
                        end else begin
                            r_acc    <= '0;
                            r_status <= i_req.status;
                            r_state  <= S_HOLD;
                        end
                    end
                end
                S_ERA: begin
                    r_era1  <= mac_p[29:24];
                    r_state <= S_YOE;
                end
                S_YOE: begin
                    r_yoe   <= mac_p[8:0];
                    r_state <= S_Q100;
                end
                S_Q100: begin
                    r_q100  <= mac_p[13:12];
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_t     <= mac_p[17:0];
                    r_state <= S_DOY;
                end
                S_DOY: begin
                    r_doy0  <= mac_p[34:20];
                    r_state <= S_DOE;
                end
                S_DOE: begin
                    r_doe   <= mac_p[18:0];
                    r_state <= S_DAYS;
                end
                S_DAYS: begin
                    r_acc   <= mac_p;
                    r_state <= S_MSD;
                end
                S_MSD: begin
                    r_acc   <= mac_p;
                    r_state <= S_MSH;
                end
                S_MSH: begin
                    r_acc   <= mac_p;
                    r_state <= S_MSM;
                end
                S_MSM: begin
                    r_acc   <= mac_p;
                    r_state <= S_MSS;
                end
                S_MSS: begin
                    r_acc    <= mac_p;
                    r_status <= dte_pkg::ST_OK;
                    r_state  <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_HOLD);
    assign o_res_ts     = r_acc;
    assign o_res_status = r_status;

    // a new request only arrives while the sequencer is free
    a_req_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> (r_state == S_IDLE))
        else $error("request while conversion busy");

    // the last millisecond step hands an ok result to the hold state
    a_last_step_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MSS) |=> ((r_state == S_HOLD) && (r_status == dte_pkg::ST_OK)))
        else $error("conversion did not finish with ok status");

    // error results always carry a zero timestamp
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HOLD) && (r_status != dte_pkg::ST_OK)) |-> (r_acc == '0))
        else $error("error result with nonzero timestamp");

endmodule

`default_nettype wire

/* hw/rtl/datetime_text_to_epoch_ms_core.sv */
// datetime_text_to_epoch_ms_core: top level with apb registers, parser, converter, output register
// depends on dte_pkg, dte_parser, dte_conv
`timescale 1ns / 1ps
`default_nettype none

// Text bytes come in on the s_axis channel, one per request: tdata carries the byte and
// tuser flags the first byte of a date. Each byte is matched against the format held in
// the apb registers (format words at 0x00..0x18, length at 0x20). A byte that neither
// fails nor ends the format gives no result. A failing byte, or the byte at the last
// format position, gives one result on m_axis: tdata is the signed 53-bit millisecond
// count, tuser the status (0 ok, 1 mismatch, 2 field overflow). The calendar conversion
// runs eleven steps through one shared multiply-add unit, then the hold state passes a
// completed date to the output register; an error result goes straight to the hold
// state, and s_axis_tready stays low until the converter is back in its idle state.
// A finished result sits in the output register while m_axis_tready is low; the block
// takes new bytes meanwhile and stalls only when a second result would need the register.
// Reset clears the format to all zero bytes with length 1 and leaves the parser idle
// until a byte marked as the start of a date arrives.

module datetime_text_to_epoch_ms_core #(
    parameter int MAX_FORMAT_LEN = dte_pkg::MAX_FORMAT_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // text input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic [0:0]  s_axis_tuser,   // [0] start_req
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [52:0] timestamp_ms, [55:53] zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    logic [3:0][63:0] r_fmt;
    logic [5:0]       r_len;

    logic                      r_out_valid;
    logic [dte_pkg::TS_W-1:0]  r_out_ts;
    logic [1:0]                r_out_status;

    logic                      cfg_wr;
    logic                      in_accept;
    logic                      out_free;
    dte_pkg::t_fields          fields;
    dte_pkg::t_req             req;
    logic                      conv_idle;
    logic                      res_valid;
    logic [dte_pkg::TS_W-1:0]  res_ts;
    logic [1:0]                res_status;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= '0;
            r_len <= 6'd1;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                dte_pkg::REG_FMT0: r_fmt[0] <= pwdata;
                dte_pkg::REG_FMT1: r_fmt[1] <= pwdata;
                dte_pkg::REG_FMT2: r_fmt[2] <= pwdata;
                dte_pkg::REG_FMT3: r_fmt[3] <= pwdata;
                dte_pkg::REG_LEN:  r_len    <= pwdata[5:0];
                default:           r_len    <= r_len;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            dte_pkg::REG_FMT0: prdata = r_fmt[0];
            dte_pkg::REG_FMT1: prdata = r_fmt[1];
            dte_pkg::REG_FMT2: prdata = r_fmt[2];
            dte_pkg::REG_FMT3: prdata = r_fmt[3];
            dte_pkg::REG_LEN:  prdata = {58'd0, r_len};
            default:           prdata = '0;
        endcase
    end

    assign s_axis_tready = conv_idle;
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid | m_axis_tready;

    dte_parser #(
        .MAX_FORMAT_LEN (MAX_FORMAT_LEN)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (s_axis_tdata),
        .i_start  (s_axis_tuser[0]),
        .i_fmt    (r_fmt),
        .i_len    (r_len),
        .o_fields (fields),
        .o_req    (req)
    );

    dte_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_fields     (fields),
        .i_out_free   (out_free),
        .o_idle       (conv_idle),
        .o_res_valid  (res_valid),
        .o_res_ts     (res_ts),
        .o_res_status (res_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out_ts     <= res_ts;
            r_out_status <= res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_ts};
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for datetime_text_to_epoch_ms_core, text bytes in, epoch ms out
// depends on dte_pkg and the core rtl; keeps its own format parser and calendar model
`timescale 1ns / 1ps

module tb_top;

    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_LIMIT    = 3000;
    localparam int ITEM_GOAL     = 800;

    // register setups used by the directed rows
    localparam logic [1:0] DIR_NO_CFG   = 2'd0;
    localparam logic [1:0] DIR_FMT_OVF  = 2'd1;
    localparam logic [1:0] DIR_FMT_LEN0 = 2'd2;

    // kinds of format used by the random phases
    localparam int PH_ISO     = 0;
    localparam int PH_COMPACT = 1;
    localparam int PH_MIXED   = 2;
    localparam int PH_LETTERS = 3;
    localparam int PH_SHORT   = 4;
    localparam int PH_FULL    = 5;
    localparam int PH_COUNT   = 6;

    typedef struct packed {
        logic [1:0]  status;
        logic [52:0] stamp;
    } t_outcome;

    typedef struct packed {
        logic [1:0] cfg;
        logic [7:0] ch;
        logic       start;
        logic       typed;
        t_outcome   want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] character
    logic [0:0]  s_axis_tuser = '0;   // [0] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // [52:0] timestamp_ms, [55:53] zero
    logic [1:0]  m_axis_tuser;        // [1:0] status

    always #1 i_clk = ~i_clk;

    datetime_text_to_epoch_ms_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // parser shadow
    logic [63:0]      fmt_words [4];
    logic [5:0]       fmt_len_reg;
    int unsigned      parse_pos;
    bit               parsing;
    dte_pkg::t_fields fields;
    bit               field_ovf;

    t_outcome pending_stamps [$];
    t_dir_row dir_rows [$];
    t_outcome head_stamp;
    int       errors = 0;
    int       items_used = 0;
    int       idle_cycles = 0;
    bit       tx_steady = 1'b0;
    bit       rx_steady = 1'b0;
    int       rx_hold = 0;
    int       rx_roll;
    int       phase_num;

    function automatic int unsigned eff_len();
        if (fmt_len_reg == 6'd0) return 1;
        if (fmt_len_reg > 6'd32) return 32;
        return 32'(fmt_len_reg);
    endfunction

    function automatic logic [7:0] fmt_at(int unsigned idx);
        if (idx >= 32) return 8'h00;
        return fmt_words[idx / 8][(idx % 8) * 8 +: 8];
    endfunction

    function automatic bit is_letter(logic [7:0] f);
        case (f)
            dte_pkg::CH_YEAR, dte_pkg::CH_MONTH, dte_pkg::CH_DAY, dte_pkg::CH_HOUR,
            dte_pkg::CH_MINUTE, dte_pkg::CH_SECOND, dte_pkg::CH_MILLI: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 6))
            0: return dte_pkg::CH_YEAR;
            1: return dte_pkg::CH_MONTH;
            2: return dte_pkg::CH_DAY;
            3: return dte_pkg::CH_HOUR;
            4: return dte_pkg::CH_MINUTE;
            5: return dte_pkg::CH_SECOND;
            default: return dte_pkg::CH_MILLI;
        endcase
    endfunction

    function automatic logic [7:0] mixed_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return ($urandom_range(0, 9) < 6) ? pick_letter() : b;
    endfunction

    function automatic logic [7:0] good_char(int unsigned p);
        logic [7:0] f;
        logic [7:0] d;
        f = fmt_at(p);
        d = 8'($urandom_range(0, 9));
        return is_letter(f) ? dte_pkg::CH_ZERO + d : f;
    endfunction

    function automatic logic [255:0] fmt_text(string s, logic [255:0] filler);
        logic [255:0] r;
        r = filler;
        for (int i = 0; i < s.len(); i++) r[8*i +: 8] = s[i];
        return r;
    endfunction

    // saturating decimal accumulate
    function automatic logic [13:0] add_decimal(logic [13:0] cur, logic [13:0] maxv,
                                                logic [3:0] d);
        int unsigned v;
        v = 32'(cur) * 10 + 32'(d);
        if (v > 32'(maxv)) begin
            v = 32'(maxv);
            field_ovf = 1'b1;
        end
        return 14'(v);
    endfunction

    // days since 1970-01-01, division truncates toward zero
    function automatic longint civil_day_count(longint y_in, longint m, longint d);
        longint y, era, yoe, mp, doy, doe;
        y = (m <= 2) ? y_in - 1 : y_in;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic longint epoch_millis();
        longint days, secs;
        days = civil_day_count(longint'(fields.year), longint'(fields.month),
                               longint'(fields.day));
        secs = days * 86400 + longint'(fields.hour) * 3600
             + longint'(fields.minute) * 60 + longint'(fields.second);
        return secs * 1000 + longint'(fields.milli);
    endfunction

    task automatic parse_char(input logic [7:0] ch, input bit st, output bit used,
                              output bit got, output t_outcome res);
        logic [7:0]  f;
        bit          dig;
        logic [3:0]  d;
        logic [13:0] m10;
        longint      ms;
        used = 1'b0;
        got = 1'b0;
        res.status = dte_pkg::ST_OK;
        res.stamp = '0;
        if (st) begin
            fields = '0;
            parse_pos = 0;
            field_ovf = 1'b0;
            parsing = 1'b1;
        end
        if (!parsing) return;
        used = 1'b1;
        f = fmt_at(parse_pos);
        dig = (ch >= dte_pkg::CH_ZERO) && (ch <= dte_pkg::CH_NINE);
        d = dig ? 4'(ch - dte_pkg::CH_ZERO) : 4'd0;
        m10 = {4'd0, dte_pkg::FIELD10_MAX};
        if (is_letter(f) ? !dig : (ch != f)) begin
            parsing = 1'b0;
            got = 1'b1;
            res.status = dte_pkg::ST_MISMATCH;
            return;
        end
        case (f)
            dte_pkg::CH_YEAR:
                fields.year = add_decimal(fields.year, dte_pkg::YEAR_MAX, d);
            dte_pkg::CH_MONTH:
                fields.month = 10'(add_decimal({4'd0, fields.month}, m10, d));
            dte_pkg::CH_DAY:
                fields.day = 10'(add_decimal({4'd0, fields.day}, m10, d));
            dte_pkg::CH_HOUR:
                fields.hour = 10'(add_decimal({4'd0, fields.hour}, m10, d));
            dte_pkg::CH_MINUTE:
                fields.minute = 10'(add_decimal({4'd0, fields.minute}, m10, d));
            dte_pkg::CH_SECOND:
                fields.second = 10'(add_decimal({4'd0, fields.second}, m10, d));
            dte_pkg::CH_MILLI:
                fields.milli = 10'(add_decimal({4'd0, fields.milli}, m10, d));
            default: ;
        endcase
        parse_pos = (parse_pos + 1) & 63;
        if (parse_pos < eff_len()) return;
        parsing = 1'b0;
        got = 1'b1;
        if (field_ovf) begin
            res.status = dte_pkg::ST_OVERFLOW;
        end else begin
            ms = epoch_millis();
            res.stamp = ms[52:0];
        end
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            dte_pkg::REG_LEN: fmt_len_reg = val[5:0];
            default:          fmt_words[idx[1:0]] = val;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_format(input logic [255:0] f, input logic [5:0] n);
        logic [63:0] lv;
        lv = {$urandom, $urandom};
        lv[5:0] = n;
        apb_write(dte_pkg::REG_FMT0, f[63:0]);
        apb_write(dte_pkg::REG_FMT1, f[127:64]);
        apb_write(dte_pkg::REG_FMT2, f[191:128]);
        apb_write(dte_pkg::REG_FMT3, f[255:192]);
        apb_write(dte_pkg::REG_LEN, lv);
    endtask

    // hold the sender until every result is out and the converter has gone quiet
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int gap_len();
        int roll;
        if (tx_steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_char(input logic [7:0] ch, input bit st, input bit typed,
                             input t_outcome want);
        int       gap;
        bit       used, got;
        t_outcome res;
        gap = gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tuser <= st;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_char(ch, st, used, got, res);
        if (used) items_used++;
        if (got || typed) begin
            pending_stamps.insert(pending_stamps.size(), typed ? want : res);
        end
    endtask

    task automatic send_date();
        int unsigned n, cut;
        int          roll;
        logic [7:0]  f, c;
        n = eff_len();
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            for (int unsigned p = 0; p < n; p++) send_char(good_char(p), p == 0, 1'b0, '0);
        end else if (roll < 82) begin
            // clean prefix, then a byte that cannot match
            cut = $urandom_range(0, n - 1);
            for (int unsigned p = 0; p < cut; p++) send_char(good_char(p), p == 0, 1'b0, '0);
            f = fmt_at(cut);
            if (is_letter(f)) begin
                do c = 8'($urandom_range(0, 255));
                while (c >= dte_pkg::CH_ZERO && c <= dte_pkg::CH_NINE);
            end else begin
                c = f ^ (8'h01 << $urandom_range(0, 7));
            end
            send_char(c, cut == 0, 1'b0, '0);
        end else if (roll < 92) begin
            // left unfinished, the next start restarts it
            cut = (n > 1) ? $urandom_range(1, n - 1) : 1;
            for (int unsigned p = 0; p < cut; p++) send_char(good_char(p), p == 0, 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 4))
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int num);
        logic [255:0] f;
        logic [5:0]   n;
        int           kind;
        for (int i = 0; i < 8; i++) f[32*i +: 32] = $urandom;
        kind = num % PH_COUNT;
        case (kind)
            PH_ISO: begin
                f = fmt_text("YYYY-MM-DDThh:mm:ss.fff", f);
                n = 6'd23;
            end
            PH_COMPACT: begin
                f = fmt_text("YYYYMMDDhhmmssfff", f);
                n = 6'd17;
            end
            PH_MIXED: begin
                for (int i = 0; i < 32; i++) f[8*i +: 8] = mixed_char();
                n = 6'($urandom_range(0, 63));
            end
            PH_LETTERS: begin
                // long letter runs drive the fields into saturation
                for (int i = 0; i < 32; i++) f[8*i +: 8] = pick_letter();
                n = (num < PH_COUNT) ? 6'd63 : 6'($urandom_range(8, 32));
            end
            PH_SHORT: begin
                for (int i = 0; i < 4; i++) f[8*i +: 8] = mixed_char();
                n = 6'($urandom_range(1, 4));
            end
            default: begin
                for (int i = 0; i < 32; i++) f[8*i +: 8] = mixed_char();
                n = 6'd32;
            end
        endcase
        settle();
        write_format(f, n);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        repeat ((kind == PH_SHORT) ? $urandom_range(10, 30) : $urandom_range(3, 8))
            send_date();
        // close on a whole date so the parser is idle before the next register writes
        for (int unsigned p = 0; p < eff_len(); p++) send_char(good_char(p), p == 0, 1'b0, '0);
    endtask

    task automatic add_row(input logic [1:0] cfg, input logic [7:0] ch, input bit st,
                           input bit typed, input logic [1:0] status,
                           input logic [52:0] stamp);
        t_dir_row r;
        r.cfg = cfg;
        r.ch = ch;
        r.start = st;
        r.typed = typed;
        r.want.status = status;
        r.want.stamp = stamp;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_text(input logic [1:0] cfg, input string s, input bit typed,
                            input logic [1:0] status, input logic [52:0] stamp);
        for (int i = 0; i < s.len(); i++)
            add_row((i == 0) ? cfg : DIR_NO_CFG, s[i], i == 0,
                    typed && (i == s.len() - 1), status, stamp);
    endtask

    // result receiver with random stalls
    always @(negedge i_clk) begin
        if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 75) begin
                m_axis_tready <= 1'b1;
            end else if (rx_roll < 95) begin
                m_axis_tready <= 1'b0;
                rx_hold = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                rx_hold = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_stamps.size() == 0) begin
                errors++;
                $display("%0t: result expected none got status %0d stamp %0d", $time,
                         m_axis_tuser, $signed(m_axis_tdata[52:0]));
            end else begin
                head_stamp = pending_stamps.pop_front();
                if (m_axis_tuser !== head_stamp.status) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time,
                             head_stamp.status, m_axis_tuser);
                end
                if (m_axis_tdata[52:0] !== head_stamp.stamp) begin
                    errors++;
                    $display("%0t: timestamp expected %0d got %0d", $time,
                             $signed(head_stamp.stamp), $signed(m_axis_tdata[52:0]));
                end
                if (m_axis_tdata[55:53] !== 3'b000) begin
                    errors++;
                    $display("%0t: tdata pad expected 0 got %0h", $time,
                             m_axis_tdata[55:53]);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 4; i++) fmt_words[i] = '0;
        fmt_len_reg = 6'd1;
        parsing = 1'b0;
        parse_pos = 0;
        fields = '0;
        field_ovf = 1'b0;

        // reset format: one zero byte
        add_row(DIR_NO_CFG, 8'h41, 1'b0, 1'b0, dte_pkg::ST_OK, '0);   // dropped while idle
        add_row(DIR_NO_CFG, 8'h00, 1'b1, 1'b0, dte_pkg::ST_OK, '0);   // all fields zero
        add_row(DIR_NO_CFG, 8'hFF, 1'b1, 1'b1, dte_pkg::ST_MISMATCH, '0);
        // five year digits overflow the year field
        add_text(DIR_FMT_OVF, "999991-1", 1'b1, dte_pkg::ST_OVERFLOW, '0);
        // a non-digit still wins over an earlier overflow
        add_text(DIR_NO_CFG, "99999x", 1'b1, dte_pkg::ST_MISMATCH, '0);
        // restart in the middle of a date
        add_text(DIR_NO_CFG, "01", 1'b0, dte_pkg::ST_OK, '0);
        add_text(DIR_NO_CFG, "019701-2", 1'b1, dte_pkg::ST_OK, 53'd86400000);
        // length register zero behaves as one
        add_row(DIR_FMT_LEN0, 8'h23, 1'b1, 1'b0, dte_pkg::ST_OK, '0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg != DIR_NO_CFG) begin
                settle();
                case (dir_rows[i].cfg)
                    DIR_FMT_OVF: write_format(fmt_text("YYYYYM-D", '0), 6'd8);
                    default:     write_format(fmt_text("#", '1), 6'd0);
                endcase
            end
            send_char(dir_rows[i].ch, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);
        end

        phase_num = 0;
        while (items_used < ITEM_GOAL) begin
            run_phase(phase_num);
            phase_num++;
        end

        settle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
